@@ rtl/assert_macros.svh @@
// Assertion macros used by the complex arithmetic unit RTL.
// Included by modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, sampled on clk, off during reset.
`define CAU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication check: cons must hold in the cycle where ante holds.
`define CAU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/cau_pkg.sv @@
// Package for the complex arithmetic unit: action codes, pipeline item type,
// and the 16-bit saturation helper. No dependencies.
`default_nettype none

package cau_pkg;

    localparam logic [2:0] ACT_ADD = 3'd0;
    localparam logic [2:0] ACT_SUB = 3'd1;
    localparam logic [2:0] ACT_MUL = 3'd2;
    localparam logic [2:0] ACT_DIV = 3'd3;
    localparam logic [2:0] ACT_MOD = 3'd4;

    localparam int QW    = 17;  // quotient bits kept by the divider
    localparam int RW    = 48;  // divider remainder width
    localparam int DW    = 32;  // |b|^2 and |a|^2 width
    localparam int SW    = 32;  // square root work width
    localparam int NSTEP = 17;  // iteration stages

    localparam logic [15:0] RES_MAX = 16'h7fff;
    localparam logic [15:0] RES_MIN = 16'h8000;

    typedef struct packed {
        logic        ovf;
        logic [15:0] val;
    } sat_t;

    typedef struct packed {
        logic [2:0]    act;
        logic [15:0]   s_re;
        logic [15:0]   s_im;
        logic          s_ovf;
        logic          dz;
        logic          neg_re;
        logic          neg_im;
        logic          big_re;
        logic          big_im;
        logic [RW-1:0] rem_re;
        logic [RW-1:0] rem_im;
        logic [DW-1:0] den;
        logic [QW-1:0] q_re;
        logic [QW-1:0] q_im;
        logic [SW-1:0] sq_x;
        logic [SW-1:0] sq_r;
    } st_t;

    function automatic sat_t sat34(input logic signed [33:0] v);
        sat_t s;
        if (v > 34'sd32767)
        begin
            s.ovf = 1'b1;
            s.val = RES_MAX;
        end
        else if (v < -34'sd32768)
        begin
            s.ovf = 1'b1;
            s.val = RES_MIN;
        end
        else
        begin
            s.ovf = 1'b0;
            s.val = v[15:0];
        end
        return s;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cau_front.sv @@
// Front end of the complex arithmetic unit: products, sums, divider setup.
// Three register stages; uses cau_pkg.
`default_nettype none

module cau_front #(
    parameter int FRAC_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [2:0]         action,
    input  logic signed [15:0] a_re,
    input  logic signed [15:0] a_im,
    input  logic signed [15:0] b_re,
    input  logic signed [15:0] b_im,
    output logic               vld,
    output cau_pkg::st_t       st
);
    import cau_pkg::*;

    localparam int CW = (DW + FRAC_BITS > RW + 1) ? DW + FRAC_BITS : RW + 1;

    // stage 1: products
    logic               v1_reg;
    logic [2:0]         act1_reg;
    logic signed [15:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;
    logic signed [31:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, sq0_reg, sq1_reg;
    logic signed [15:0] x0, x1;
    logic signed [31:0] p_rr_next, p_ii_next, p_ri_next, p_ir_next, sq0_next, sq1_next;

    // stage 2: sums
    logic               v2_reg;
    logic [2:0]         act2_reg;
    sat_t               s_re2_reg, s_im2_reg;
    logic [DW-1:0]      den2_reg;
    logic signed [33:0] nre2_reg, nim2_reg;
    sat_t               s_re_next, s_im_next;
    logic signed [33:0] as_re, as_im, mul_re, mul_im;

    // stage 3: divider setup
    logic               v3_reg;
    st_t                st3_reg;
    st_t                st3_next;
    logic [33:0]        mag_re, mag_im;
    logic [CW-1:0]      num_re, num_im, dlim;

    assign x0 = (action == ACT_MOD) ? a_re : b_re;
    assign x1 = (action == ACT_MOD) ? a_im : b_im;
    assign p_rr_next = a_re * b_re;
    assign p_ii_next = a_im * b_im;
    assign p_ri_next = a_re * b_im;
    assign p_ir_next = a_im * b_re;
    assign sq0_next  = x0 * x0;
    assign sq1_next  = x1 * x1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            act1_reg <= action;
            ar1_reg  <= a_re;
            ai1_reg  <= a_im;
            br1_reg  <= b_re;
            bi1_reg  <= b_im;
            p_rr_reg <= p_rr_next;
            p_ii_reg <= p_ii_next;
            p_ri_reg <= p_ri_next;
            p_ir_reg <= p_ir_next;
            sq0_reg  <= sq0_next;
            sq1_reg  <= sq1_next;
        end
    end

    always_comb
    begin
        if (act1_reg == ACT_SUB)
        begin
            as_re = 34'(ar1_reg) - 34'(br1_reg);
            as_im = 34'(ai1_reg) - 34'(bi1_reg);
        end
        else
        begin
            as_re = 34'(ar1_reg) + 34'(br1_reg);
            as_im = 34'(ai1_reg) + 34'(bi1_reg);
        end
        // floor shift of the full-precision products
        mul_re = (34'(p_rr_reg) - 34'(p_ii_reg)) >>> FRAC_BITS;
        mul_im = (34'(p_ri_reg) + 34'(p_ir_reg)) >>> FRAC_BITS;
        case (act1_reg)
            ACT_ADD, ACT_SUB:
            begin
                s_re_next = sat34(as_re);
                s_im_next = sat34(as_im);
            end
            ACT_MUL:
            begin
                s_re_next = sat34(mul_re);
                s_im_next = sat34(mul_im);
            end
            default:
            begin
                s_re_next = '0;
                s_im_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            act2_reg  <= act1_reg;
            s_re2_reg <= s_re_next;
            s_im2_reg <= s_im_next;
            den2_reg  <= DW'(sq0_reg) + DW'(sq1_reg);
            nre2_reg  <= 34'(p_rr_reg) + 34'(p_ii_reg);
            nim2_reg  <= 34'(p_ir_reg) - 34'(p_ri_reg);
        end
    end

    always_comb
    begin
        mag_re = nre2_reg[33] ? 34'(-nre2_reg) : 34'(nre2_reg);
        mag_im = nim2_reg[33] ? 34'(-nim2_reg) : 34'(nim2_reg);
        num_re = CW'(mag_re[DW-1:0]) << FRAC_BITS;
        num_im = CW'(mag_im[DW-1:0]) << FRAC_BITS;
        dlim   = CW'(den2_reg) << QW;

        st3_next.act    = act2_reg;
        st3_next.s_re   = s_re2_reg.val;
        st3_next.s_im   = s_im2_reg.val;
        st3_next.s_ovf  = s_re2_reg.ovf | s_im2_reg.ovf;
        st3_next.dz     = (den2_reg == '0);
        st3_next.neg_re = nre2_reg[33];
        st3_next.neg_im = nim2_reg[33];
        st3_next.big_re = (num_re >= dlim);
        st3_next.big_im = (num_im >= dlim);
        st3_next.rem_re = num_re[RW-1:0];
        st3_next.rem_im = num_im[RW-1:0];
        st3_next.den    = den2_reg;
        st3_next.q_re   = '0;
        st3_next.q_im   = '0;
        st3_next.sq_x   = den2_reg;
        st3_next.sq_r   = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st3_reg <= st3_next;
        end
    end

    assign vld = v3_reg;
    assign st  = st3_reg;

endmodule

`default_nettype wire

@@ rtl/cau_step.sv @@
// One iteration stage: a restoring divide step for both quotient parts and,
// from the second stage on, one square root step. Uses cau_pkg.
`default_nettype none

module cau_step #(
    parameter int STEP = 0
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         vld_in,
    input  cau_pkg::st_t st_in,
    output logic         vld_out,
    output cau_pkg::st_t st_out
);
    import cau_pkg::*;

    localparam int QI = QW - 1 - STEP;
    localparam int SB = SW - 2 * STEP;

    logic          vld_reg;
    st_t           st_reg;
    st_t           st_next;
    logic [RW-1:0] d_sh;
    logic [SW-1:0] sq_bit;
    logic [SW:0]   sq_t;

    always_comb
    begin
        st_next = st_in;
        d_sh    = RW'(st_in.den) << QI;
        sq_bit  = SW'(1) << SB;
        sq_t    = (SW+1)'(st_in.sq_r) + (SW+1)'(sq_bit);
        if (st_in.rem_re >= d_sh)
        begin
            st_next.rem_re   = st_in.rem_re - d_sh;
            st_next.q_re[QI] = 1'b1;
        end
        if (st_in.rem_im >= d_sh)
        begin
            st_next.rem_im   = st_in.rem_im - d_sh;
            st_next.q_im[QI] = 1'b1;
        end
        if (STEP >= 1)
        begin
            if ((SW+1)'(st_in.sq_x) >= sq_t)
            begin
                st_next.sq_x = st_in.sq_x - sq_t[SW-1:0];
                st_next.sq_r = (st_in.sq_r >> 1) + sq_bit;
            end
            else
            begin
                st_next.sq_r = st_in.sq_r >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign vld_out = vld_reg;
    assign st_out  = st_reg;

endmodule

`default_nettype wire

@@ rtl/complex_arithmetic_unit.sv @@
// Complex arithmetic unit top level: front end, iteration chain, result stage.
// Depends on cau_pkg, cau_front, cau_step and assert_macros.svh.
`default_nettype none

// Complex ALU on signed fixed-point operands (FRAC_BITS fraction bits, Q8.8 by
// default): add, subtract, multiply, divide and modulus of a, one result item
// per input item, saturated to 16 bits with an overflow flag; divide by a zero
// b gives zero and div_by_zero. The unit is a fixed pipeline of 21 register
// stages: three front stages (products, sums, divider setup), seventeen
// iteration stages (one quotient bit each, and from the second on one square
// root bit) and the output register. An item passes through them in order,
// and one item can be accepted each cycle while in_ready is high. The whole
// pipeline advances together; it holds only while a result sits in the output
// register and out_ready is low, so in_ready = !out_valid || out_ready.
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         action,
    input  logic signed [15:0] a_re,
    input  logic signed [15:0] a_im,
    input  logic signed [15:0] b_re,
    input  logic signed [15:0] b_im,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] res_re,
    output logic signed [15:0] res_im,
    output logic               div_by_zero,
    output logic               overflow
);
    import cau_pkg::*;
    `include "assert_macros.svh"

    // Saturate a divider quotient back to a signed 16-bit result.
    function automatic sat_t div_fix(input logic [QW-1:0] q, input logic neg,
                                     input logic big);
        sat_t s;
        if (big)
        begin
            s.ovf = 1'b1;
            s.val = neg ? RES_MIN : RES_MAX;
        end
        else if (!neg)
        begin
            s.ovf = (q > QW'(32767));
            s.val = s.ovf ? RES_MAX : q[15:0];
        end
        else
        begin
            s.ovf = (q > QW'(32768));
            s.val = s.ovf ? RES_MIN : 16'(-q);
        end
        return s;
    endfunction

    logic        en;
    logic        vld_c [0:NSTEP];
    st_t         st_c  [0:NSTEP];
    st_t         fin;

    logic        out_valid_reg;
    logic [15:0] res_re_reg, res_im_reg;
    logic        dz_reg, ovf_reg;
    logic [2:0]  act_out_reg;

    logic [15:0] res_re_next, res_im_next;
    logic        dz_next, ovf_next;
    sat_t        dq_re, dq_im;

    // Advance everything unless a result is stuck in the output register.
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    cau_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_valid(in_valid),
        .action  (action),
        .a_re    (a_re),
        .a_im    (a_im),
        .b_re    (b_re),
        .b_im    (b_im),
        .vld     (vld_c[0]),
        .st      (st_c[0])
    );

    for (genvar k = 0; k < NSTEP; k++)
    begin : g_step
        cau_step #(
            .STEP(k)
        ) u_step (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .vld_in (vld_c[k]),
            .st_in  (st_c[k]),
            .vld_out(vld_c[k+1]),
            .st_out (st_c[k+1])
        );
    end

    assign fin = st_c[NSTEP];

    // Pick the result for the item's action.
    always_comb
    begin
        dq_re       = div_fix(fin.q_re, fin.neg_re, fin.big_re);
        dq_im       = div_fix(fin.q_im, fin.neg_im, fin.big_im);
        res_re_next = '0;
        res_im_next = '0;
        dz_next     = 1'b0;
        ovf_next    = 1'b0;
        case (fin.act)
            ACT_ADD, ACT_SUB, ACT_MUL:
            begin
                res_re_next = fin.s_re;
                res_im_next = fin.s_im;
                ovf_next    = fin.s_ovf;
            end
            ACT_DIV:
            begin
                if (fin.dz)
                begin
                    dz_next = 1'b1;
                end
                else
                begin
                    res_re_next = dq_re.val;
                    res_im_next = dq_im.val;
                    ovf_next    = dq_re.ovf | dq_im.ovf;
                end
            end
            ACT_MOD:
            begin
                // root of |a|^2 can reach 46340, past the positive limit
                if (fin.sq_r > SW'(32767))
                begin
                    res_re_next = RES_MAX;
                    ovf_next    = 1'b1;
                end
                else
                begin
                    res_re_next = fin.sq_r[15:0];
                end
            end
            default:
            begin
                res_re_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_c[NSTEP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_re_reg  <= res_re_next;
            res_im_reg  <= res_im_next;
            dz_reg      <= dz_next;
            ovf_reg     <= ovf_next;
            act_out_reg <= fin.act;
        end
    end

    assign out_valid   = out_valid_reg;
    assign res_re      = res_re_reg;
    assign res_im      = res_im_reg;
    assign div_by_zero = dz_reg;
    assign overflow    = ovf_reg;

    `CAU_ASSERT_IMP(a_dz_zero, out_valid_reg && dz_reg,
        res_re_reg == '0 && res_im_reg == '0 && !ovf_reg && act_out_reg == ACT_DIV,
        "div_by_zero item carries a nonzero result")
    `CAU_ASSERT_IMP(a_mod_im, out_valid_reg && act_out_reg == ACT_MOD,
        res_im_reg == '0 && !dz_reg && !res_re_reg[15],
        "modulus item with imaginary part or negative value")
    `CAU_ASSERT_IMP(a_ovf_sat, out_valid_reg && ovf_reg,
        res_re_reg == RES_MAX || res_re_reg == RES_MIN ||
        res_im_reg == RES_MAX || res_im_reg == RES_MIN,
        "overflow raised without a saturated part")

endmodule

`default_nettype wire

@@ tb/complex_arithmetic_unit_test.sv @@
// Testbench for the complex arithmetic unit: directed and random operand items
// checked against a fixed-point predictor. Depends on cau_pkg and the RTL top.
`timescale 1ns / 1ps

module complex_arithmetic_unit_test;
    import cau_pkg::*;

    typedef struct {
        logic [15:0] re;
        logic [15:0] im;
        logic        dz;
        logic        ovf;
    } cplx_res_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         action = ACT_ADD;
    logic signed [15:0] a_re = '0;
    logic signed [15:0] a_im = '0;
    logic signed [15:0] b_re = '0;
    logic signed [15:0] b_im = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] res_re;
    logic signed [15:0] res_im;
    logic               div_by_zero;
    logic               overflow;

    cplx_res_t   pending_results[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          idle_enable = 1'b1;
    int          hold_cycles = 0;   // long receiver hold-off when nonzero
    logic [15:0] div_max_neg = 16'h8000;

    localparam int LATENCY = 21;
    localparam int CYCLE_LIMIT = 200000;

    complex_arithmetic_unit i_dut (.*);

    always #4 clk = ~clk;

    // Clamp a wide value into the signed 16-bit range; flag when clamped.
    function automatic logic [15:0] clamp16(input longint v, inout logic ovf);
        if (v > 32767)
        begin
            ovf = 1'b1;
            return 16'h7fff;
        end
        if (v < -32768)
        begin
            ovf = 1'b1;
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    // Floor division by 2^8 on signed values.
    function automatic longint floor_shift(input longint v);
        return v >>> 8;
    endfunction

    // Truncating fixed-point quotient (num << 8) / den, den > 0.
    function automatic logic [15:0] quotient_q88(input longint num, input longint den,
                                                 inout logic ovf);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag * 256) / den;
        return clamp16((num < 0) ? -q : q, ovf);
    endfunction

    function automatic longint int_sqrt(input longint x);
        longint r;
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 65536;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= x)
                lo = mid;
            else
                hi = mid - 1;
        end
        r = lo;
        return r;
    endfunction

    function automatic cplx_res_t predict_complex(input logic [2:0] op,
            input logic signed [15:0] ar16, input logic signed [15:0] ai16,
            input logic signed [15:0] br16, input logic signed [15:0] bi16);
        cplx_res_t r;
        longint ar;
        longint ai;
        longint br;
        longint bi;
        longint den;
        longint m;
        ar = ar16;
        ai = ai16;
        br = br16;
        bi = bi16;
        r.re = '0;
        r.im = '0;
        r.dz = 1'b0;
        r.ovf = 1'b0;
        case (op)
            ACT_ADD:
            begin
                r.re = clamp16(ar + br, r.ovf);
                r.im = clamp16(ai + bi, r.ovf);
            end
            ACT_SUB:
            begin
                r.re = clamp16(ar - br, r.ovf);
                r.im = clamp16(ai - bi, r.ovf);
            end
            ACT_MUL:
            begin
                r.re = clamp16(floor_shift(ar * br - ai * bi), r.ovf);
                r.im = clamp16(floor_shift(ar * bi + ai * br), r.ovf);
            end
            ACT_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    r.dz = 1'b1;
                else
                begin
                    r.re = quotient_q88(ar * br + ai * bi, den, r.ovf);
                    r.im = quotient_q88(ai * br - ar * bi, den, r.ovf);
                end
            end
            ACT_MOD:
            begin
                m = int_sqrt(ar * ar + ai * ai);
                r.re = clamp16(m, r.ovf);
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatch_count++;
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
    endtask

    // Offer one item at the falling edge and hold it until accepted; idle
    // randomly beforehand while idling is enabled.
    task automatic send_item(input logic [2:0] op, input logic [15:0] ar,
                             input logic [15:0] ai, input logic [15:0] br,
                             input logic [15:0] bi);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        action <= op;
        a_re <= ar;
        a_im <= ai;
        b_re <= br;
        b_im <= bi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(predict_complex(op, ar, ai, br, bi));
    endtask

    // Release valid once the last item of a phase has gone.
    task automatic stop_sending();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return '0;
            3: return 16'($signed($urandom_range(0, 1023)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic [2:0] op;
        for (int k = 0; k < 5; k++)
        begin
            op = 3'(k);
            send_item(op, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
            send_item(op, 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
            send_item(op, 16'h0100, 16'hff00, 16'h0200, 16'h0080);
        end
        // divide by zero, tiny divisor, most negative dividend, unused codes, zero modulus
        send_item(ACT_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000);
        send_item(ACT_DIV, 16'h8000, 16'h0000, 16'h0001, 16'h0000);
        send_item(ACT_DIV, div_max_neg, 16'h0000, 16'h0100, 16'h0000);
        send_item(3'd5, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_item(3'd6, 16'h1111, 16'h2222, 16'h3333, 16'h4444);
        send_item(3'd7, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_item(ACT_MOD, 16'h0000, 16'h0000, 16'hffff, 16'hffff);
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++)
            send_item(($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4)),
                      rand_operand(), rand_operand(), rand_operand(), rand_operand());
    endtask

    // Hold off the receiver for a long stretch while the sender keeps going,
    // so the pipeline fills and in_ready drops.
    task automatic test_backpressure();
        hold_cycles = 60;
        test_random(40);
    endtask

    task automatic test_streaming();
        idle_enable = 1'b0;
        test_random(200);
    endtask

    // Receiver: random stall bursts, or a counted long hold-off.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (idle_enable && $urandom_range(0, 7) == 0)
            out_ready <= 1'b0;
        else
            out_ready <= 1'b1;
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        cplx_res_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", res_re, 16'h0);
            else
            begin
                want = pending_results.pop_front();
                if (res_re !== want.re)
                    report_mismatch("res_re", res_re, want.re);
                if (res_im !== want.im)
                    report_mismatch("res_im", res_im, want.im);
                if (div_by_zero !== want.dz)
                    report_mismatch("div_by_zero", 16'(div_by_zero), 16'(want.dz));
                if (overflow !== want.ovf)
                    report_mismatch("overflow", 16'(overflow), 16'(want.ovf));
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL complex_arithmetic_unit");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(800);
        test_backpressure();
        test_streaming();
        stop_sending();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS complex_arithmetic_unit");
        else
            $display("FAIL complex_arithmetic_unit");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_step.sv
rtl/complex_arithmetic_unit.sv
tb/complex_arithmetic_unit_test.sv
